[rtl/pva_pkg.sv]
package pva_pkg;

  localparam int PosW  = 24;
  localparam int CoefW = 16;
  localparam int NrmW  = 8;
  localparam int TW    = 26;
  localparam int AbsW  = 24;
  localparam int SqW   = 51;
  localparam int SqSteps = 25;
  localparam int RootW = 26;
  localparam int QuoW  = 16;
  localparam int NumW  = 41;
  localparam int RowW  = 48;
  localparam int CfgIdxW = 3;
  localparam int DefCoefFracBits = 12;
  localparam logic [QuoW:0] UnitQ15 = 17'd32768;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ROW_X = 3'd0,
    CFG_ROW_Y = 3'd1,
    CFG_ROW_Z = 3'd2,
    CFG_OFF_X = 3'd3,
    CFG_OFF_Y = 3'd4,
    CFG_OFF_Z = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [31:0]              w;
    logic [2:0][PosW-1:0]     pos;
    logic [2:0]               neg;
    logic                     zero;
  } side_t;

  typedef logic [2:0][AbsW-1:0] abs3_t;
  typedef logic [2:0][QuoW-1:0] quo3_t;

endpackage

[rtl/packed_vertex_affine_transform_unit.sv]
// Channel  | Dir | Signals                              | Content
// s_axis   | in  | tvalid, tready, tdata[127:0]         | one packed vertex
// m_axis   | out | tvalid, tready, tdata[127:0]         | one transformed vertex
// cfg      | in  | cfg_we_i, cfg_idx_i, cfg_data_i      | matrix rows and offsets
// One word is accepted per cycle while the output is not stalled; the normal path
// holds the 25-step square root and the 16-step divider.
// Reset clears the valid bits and loads the identity matrix with zero offsets.
// A stall at the output holds every stage; no word is lost or repeated.
module packed_vertex_affine_transform_unit import pva_pkg::*; #(
  parameter int COEF_FRAC_BITS = DefCoefFracBits
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [127:0]        s_axis_tdata,  // word_x, word_y, word_z, word_w
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [127:0]        m_axis_tdata,  // out_x, out_y, out_z, out_w
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [RowW-1:0]     cfg_data_i
);

  localparam int ProdW = CoefW + PosW;
  localparam int AccW  = ((PosW + COEF_FRAC_BITS) > ProdW ?
                          (PosW + COEF_FRAC_BITS) : ProdW) + 2;
  localparam logic [CoefW-1:0] One = CoefW'(1) << COEF_FRAC_BITS;
  localparam logic [AccW-1:0]  RndMask = (AccW'(1) << COEF_FRAC_BITS) - AccW'(1);

  logic [RowW-1:0] row_q [3];
  logic [PosW-1:0] off_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q[0] <= RowW'(One);
      row_q[1] <= RowW'(One) << 16;
      row_q[2] <= RowW'(One) << 32;
      off_q[0] <= '0;
      off_q[1] <= '0;
      off_q[2] <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ROW_X: row_q[0] <= cfg_data_i;
        CFG_ROW_Y: row_q[1] <= cfg_data_i;
        CFG_ROW_Z: row_q[2] <= cfg_data_i;
        CFG_OFF_X: off_q[0] <= cfg_data_i[PosW-1:0];
        CFG_OFF_Y: off_q[1] <= cfg_data_i[PosW-1:0];
        CFG_OFF_Z: off_q[2] <= cfg_data_i[PosW-1:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic out_vld_q;
  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  // Stage 1: products.
  logic signed [ProdW-1:0]      pp_d [3][3];
  logic signed [CoefW+NrmW-1:0] np_d [3][3];
  logic signed [ProdW-1:0]      pp_q [3][3];
  logic signed [CoefW+NrmW-1:0] np_q [3][3];
  logic [31:0]                  w1_q;
  logic                         v1_q;

  always_comb begin
    logic signed [PosW-1:0]  p;
    logic signed [NrmW-1:0]  n;
    logic signed [CoefW-1:0] c;
    logic [31:0]             wd;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        wd = s_axis_tdata[32*j +: 32];
        p  = {~wd[23], wd[22:0]};
        n  = wd[31] ? -$signed({1'b0, wd[30:24]}) : $signed({1'b0, wd[30:24]});
        c  = row_q[i][16*j +: 16];
        pp_d[i][j] = ProdW'(c) * ProdW'(p);
        np_d[i][j] = (CoefW+NrmW)'(c) * (CoefW+NrmW)'(n);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pp_q <= pp_d;
      np_q <= np_d;
      w1_q <= s_axis_tdata[127:96];
    end
  end

  // Stage 2: sums.
  logic signed [AccW-1:0] acc_d [3];
  logic signed [TW-1:0]   t_d   [3];
  logic signed [AccW-1:0] acc_q [3];
  logic signed [TW-1:0]   t_q   [3];
  logic [31:0]            w2_q;
  logic                   v2_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc_d[i] = (AccW'($signed(off_q[i])) <<< COEF_FRAC_BITS)
               + AccW'(pp_q[i][0]) + AccW'(pp_q[i][1]) + AccW'(pp_q[i][2]);
      t_d[i]   = TW'(np_q[i][0]) + TW'(np_q[i][1]) + TW'(np_q[i][2]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      acc_q <= acc_d;
      t_q   <= t_d;
      w2_q  <= w1_q;
    end
  end

  // Stage 3: truncation toward zero, magnitudes and squares.
  logic [2:0][PosW-1:0]   pos_d;
  abs3_t                  abs_d;
  logic [2:0]             neg_d;
  logic [2*AbsW-1:0]      sq_d [3];
  logic [2:0][PosW-1:0]   pos3_q;
  abs3_t                  abs3_q;
  logic [2:0]             neg3_q;
  logic [2*AbsW-1:0]      sq_q [3];
  logic [31:0]            w3_q;
  logic                   v3_q;

  always_comb begin
    logic signed [AccW-1:0] a;
    logic signed [TW-1:0]   ta;
    for (int i = 0; i < 3; i++) begin
      a  = acc_q[i];
      if (a[AccW-1]) begin
        a = a + $signed(RndMask);
      end
      a  = a >>> COEF_FRAC_BITS;
      pos_d[i] = {~a[PosW-1], a[PosW-2:0]};
      ta = t_q[i][TW-1] ? -t_q[i] : t_q[i];
      abs_d[i] = ta[AbsW-1:0];
      neg_d[i] = t_q[i][TW-1];
      sq_d[i]  = (2*AbsW)'(abs_d[i]) * (2*AbsW)'(abs_d[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pos3_q <= pos_d;
      abs3_q <= abs_d;
      neg3_q <= neg_d;
      sq_q   <= sq_d;
      w3_q   <= w2_q;
    end
  end

  // Stage 4: squared length.
  logic [SqW-1:0] sum_d, sum4_q;
  abs3_t          abs4_q;
  side_t          side4_q;
  logic           v4_q;

  assign sum_d = SqW'(sq_q[0]) + SqW'(sq_q[1]) + SqW'(sq_q[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sum4_q       <= sum_d;
      abs4_q       <= abs3_q;
      side4_q.w    <= w3_q;
      side4_q.pos  <= pos3_q;
      side4_q.neg  <= neg3_q;
      side4_q.zero <= (sum_d == '0);
    end
  end

  logic  nv;
  quo3_t nq;
  side_t ns;

  pva_norm u_norm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (v4_q),
    .sum_i  (sum4_q),
    .abs_i  (abs4_q),
    .side_i (side4_q),
    .vld_o  (nv),
    .quo_o  (nq),
    .side_o (ns)
  );

  // Scale stage: cap, maximum and quantiser scale.
  logic [QuoW:0]  u_d   [3];
  logic [QuoW:0]  u5_q  [3];
  logic [QuoW:0]  umax;
  logic [6:0]     m_d, m5_q;
  logic [QuoW+8:0] mprod;
  side_t          side5_q;
  logic           v5_q;

  always_comb begin
    umax = '0;
    for (int i = 0; i < 3; i++) begin
      u_d[i] = ((QuoW+1)'(nq[i]) > UnitQ15) ? UnitQ15 : (QuoW+1)'(nq[i]);
      if (u_d[i] > umax) begin
        umax = u_d[i];
      end
    end
    mprod = (QuoW+9)'(umax) * (QuoW+9)'(127) + (QuoW+9)'(16384);
    m_d   = mprod[21:15];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (en) begin
      v5_q <= nv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      u5_q    <= u_d;
      m5_q    <= m_d;
      side5_q <= ns;
    end
  end

  // Output stage.
  logic [127:0]   out_d, out_q;
  logic           zero_q;

  always_comb begin
    logic [QuoW+7:0] mg;
    logic [7:0]      byte_v;
    for (int i = 0; i < 3; i++) begin
      mg     = (QuoW+8)'(u5_q[i]) * (QuoW+8)'(m5_q) + (QuoW+8)'(16384);
      byte_v = side5_q.zero ? 8'h00 : {side5_q.neg[i], mg[21:15]};
      out_d[32*i +: 32] = {byte_v, side5_q.pos[i]};
    end
    out_d[127:96] = side5_q.w;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q  <= out_d;
      zero_q <= side5_q.zero;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

  a_zero_normal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && zero_q |-> out_q[31:24] == 8'h00 && out_q[63:56] == 8'h00
                            && out_q[95:88] == 8'h00)
    else $error("Zero normal gave non-zero bytes.");

  a_quo_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nv && !ns.zero |-> (QuoW+1)'(nq[0]) <= UnitQ15 && (QuoW+1)'(nq[1]) <= UnitQ15
                       && (QuoW+1)'(nq[2]) <= UnitQ15)
    else $error("Normalised component above one.");

  a_scale_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v5_q |-> m5_q <= 7'd127)
    else $error("Quantiser scale out of range.");

  a_stall_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en && v1_q |=> v1_q)
    else $error("Word lost during stall.");

endmodule

[rtl/pva_norm.sv]
module pva_norm import pva_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           vld_i,
  input  logic [SqW-1:0] sum_i,
  input  abs3_t          abs_i,
  input  side_t          side_i,
  output logic           vld_o,
  output quo3_t          quo_o,
  output side_t          side_o
);

  logic [SqW-1:0] sq_rem_q  [SqSteps];
  logic [SqW-1:0] sq_res_q  [SqSteps];
  logic           sq_vld_q  [SqSteps];
  abs3_t          sq_abs_q  [SqSteps];
  side_t          sq_side_q [SqSteps];

  for (genvar k = 0; k < SqSteps; k++) begin : g_sqrt
    localparam logic [SqW-1:0] Bit = SqW'(1) << (2 * (SqSteps - 1 - k));
    logic [SqW-1:0] rem_in, res_in, trial, rem_d, res_d;
    logic           vld_in;
    abs3_t          abs_in;
    side_t          side_in;
    if (k == 0) begin : g_first
      assign rem_in  = sum_i;
      assign res_in  = '0;
      assign vld_in  = vld_i;
      assign abs_in  = abs_i;
      assign side_in = side_i;
    end else begin : g_next
      assign rem_in  = sq_rem_q[k-1];
      assign res_in  = sq_res_q[k-1];
      assign vld_in  = sq_vld_q[k-1];
      assign abs_in  = sq_abs_q[k-1];
      assign side_in = sq_side_q[k-1];
    end
    always_comb begin
      trial = res_in + Bit;
      if (rem_in >= trial) begin
        rem_d = rem_in - trial;
        res_d = (res_in >> 1) + Bit;
      end else begin
        rem_d = rem_in;
        res_d = res_in >> 1;
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_vld_q[k] <= 1'b0;
      end else if (en_i) begin
        sq_vld_q[k] <= vld_in;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sq_rem_q[k]  <= rem_d;
        sq_res_q[k]  <= res_d;
        sq_abs_q[k]  <= abs_in;
        sq_side_q[k] <= side_in;
      end
    end
  end

  logic [RootW-1:0]          root;
  logic [2:0][NumW-1:0]      num_d;
  logic [2:0][NumW-1:0]      num_q;
  logic [RootW-1:0]          dvs_q;
  logic                      pre_vld_q;
  side_t                     pre_side_q;

  assign root = sq_res_q[SqSteps-1][RootW-1:0];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num_d[i] = {NumW'(sq_abs_q[SqSteps-1][i]) << (QuoW - 1)} + NumW'(root >> 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_vld_q <= 1'b0;
    end else if (en_i) begin
      pre_vld_q <= sq_vld_q[SqSteps-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q      <= num_d;
      dvs_q      <= root;
      pre_side_q <= sq_side_q[SqSteps-1];
    end
  end

  logic [2:0][NumW-1:0] dv_rem_q  [QuoW];
  quo3_t                dv_quo_q  [QuoW];
  logic [RootW-1:0]     dv_dvs_q  [QuoW];
  logic                 dv_vld_q  [QuoW];
  side_t                dv_side_q [QuoW];

  for (genvar k = 0; k < QuoW; k++) begin : g_div
    localparam int Sh = QuoW - 1 - k;
    logic [2:0][NumW-1:0] rem_in, rem_d;
    quo3_t                quo_in, quo_d;
    logic [RootW-1:0]     dvs_in;
    logic [NumW-1:0]      dk;
    logic                 vld_in;
    side_t                side_in;
    if (k == 0) begin : g_first
      assign rem_in  = num_q;
      assign quo_in  = '0;
      assign dvs_in  = dvs_q;
      assign vld_in  = pre_vld_q;
      assign side_in = pre_side_q;
    end else begin : g_next
      assign rem_in  = dv_rem_q[k-1];
      assign quo_in  = dv_quo_q[k-1];
      assign dvs_in  = dv_dvs_q[k-1];
      assign vld_in  = dv_vld_q[k-1];
      assign side_in = dv_side_q[k-1];
    end
    assign dk = NumW'(dvs_in) << Sh;
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        if (rem_in[i] >= dk) begin
          rem_d[i] = rem_in[i] - dk;
          quo_d[i] = {quo_in[i][QuoW-2:0], 1'b1};
        end else begin
          rem_d[i] = rem_in[i];
          quo_d[i] = {quo_in[i][QuoW-2:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_vld_q[k] <= 1'b0;
      end else if (en_i) begin
        dv_vld_q[k] <= vld_in;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dv_rem_q[k]  <= rem_d;
        dv_quo_q[k]  <= quo_d;
        dv_dvs_q[k]  <= dvs_in;
        dv_side_q[k] <= side_in;
      end
    end
  end

  assign vld_o  = dv_vld_q[QuoW-1];
  assign quo_o  = dv_quo_q[QuoW-1];
  assign side_o = dv_side_q[QuoW-1];

  a_root_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_vld_q[SqSteps-1] |-> (sq_res_q[SqSteps-1] >> RootW) == '0)
    else $error("Square root wider than expected.");

endmodule

[tb/packed_vertex_affine_transform_unit_tb.sv]
module packed_vertex_affine_transform_unit_tb;
  import pva_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CfgIdxW-1:0] IdxSpareLo = 3'd6;
  localparam logic [CfgIdxW-1:0] IdxSpareHi = 3'd7;
  localparam logic [RowW-1:0]    IdentRowX  = 48'h0000_0000_1000;
  localparam logic [RowW-1:0]    IdentRowY  = 48'h0000_1000_0000;
  localparam logic [RowW-1:0]    IdentRowZ  = 48'h1000_0000_0000;
  localparam int                 DrainCycles = 60;
  localparam longint             CycleLimit = 400000;
  localparam int                 RandomItems = 1400;
  localparam int                 DirectedRows = 11;

  typedef struct {
    logic [127:0] din;
    logic [127:0] want;
    bit           typed;
  } vertex_row_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [127:0] m_axis_tdata;
  logic         cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [RowW-1:0]    cfg_data_i;

  logic [RowW-1:0]  coef_row [3];
  logic [PosW-1:0]  shift_off [3];
  logic [127:0]     pending_vertices [$];
  logic [127:0]     typed_want;
  bit               typed_flag;
  int               mismatches = 0;
  longint           cycle_count = 0;
  int               stall_mode = 0;

  packed_vertex_affine_transform_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  function automatic longint unsigned floor_root(input longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [127:0] transform_vertex(input logic [127:0] d);
    logic [31:0]     wd [3];
    logic [31:0]     res [3];
    logic [15:0]     c;
    longint          pos [3];
    longint          nrm [3];
    longint          tn [3];
    longint          acc;
    longint          q;
    longint unsigned a;
    longint unsigned s;
    longint unsigned l;
    longint unsigned u [3];
    longint unsigned umax;
    longint unsigned m;
    longint unsigned mag;
    s = 0;
    umax = 0;
    for (int j = 0; j < 3; j++) begin
      wd[j] = d[32*j +: 32];
      pos[j] = longint'(wd[j][23:0]) - longint'(24'h800000);
      nrm[j] = wd[j][31] ? -longint'(wd[j][30:24]) : longint'(wd[j][30:24]);
    end
    for (int i = 0; i < 3; i++) begin
      acc = longint'($signed(shift_off[i])) * (longint'(1) <<< DefCoefFracBits);
      tn[i] = 0;
      for (int j = 0; j < 3; j++) begin
        c = coef_row[i][16*j +: 16];
        acc += longint'($signed(c)) * pos[j];
        tn[i] += longint'($signed(c)) * nrm[j];
      end
      q = acc / (longint'(1) <<< DefCoefFracBits);
      res[i] = '0;
      res[i][23:0] = q[23:0] + 24'h800000;
      a = (tn[i] < 0) ? -tn[i] : tn[i];
      s += a * a;
    end
    if (s != 0) begin
      l = floor_root(s);
      for (int i = 0; i < 3; i++) begin
        a = (tn[i] < 0) ? -tn[i] : tn[i];
        u[i] = (a * 32768 + (l >> 1)) / l;
        if (u[i] > 32768) u[i] = 32768;
        if (u[i] > umax) umax = u[i];
      end
      m = (127 * umax + 16384) >> 15;
      for (int i = 0; i < 3; i++) begin
        mag = (u[i] * m + 16384) >> 15;
        res[i][30:24] = mag[6:0];
        res[i][31] = tn[i] < 0;
      end
    end
    return {d[127:96], res[2], res[1], res[0]};
  endfunction

  function automatic logic [127:0] random_vertex();
    logic [127:0] d;
    int           kind;
    d = {$urandom, $urandom, $urandom, $urandom};
    kind = $urandom_range(0, 9);
    for (int j = 0; j < 3; j++) begin
      if (kind == 0) d[32*j+24 +: 7] = 7'h00;
      if (kind == 1) d[32*j+24 +: 7] = 7'h7F;
      if (kind == 2) d[32*j +: 24] = $urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000;
    end
    return d;
  endfunction

  // Result checking and capture of accepted vertices.
  always @(posedge clk_i) begin
    logic [127:0] exp_word;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        pending_vertices.insert(pending_vertices.size(),
                                typed_flag ? typed_want : transform_vertex(s_axis_tdata));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_vertices.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected output word %h", m_axis_tdata);
        end else begin
          exp_word = pending_vertices.pop_front();
          for (int f = 0; f < 4; f++) begin
            if (m_axis_tdata[32*f +: 32] !== exp_word[32*f +: 32]) begin
              mismatches++;
              if (mismatches <= 10) begin
                $display("field %0d: expected %h, got %h", f, exp_word[32*f +: 32],
                         m_axis_tdata[32*f +: 32]);
              end
            end
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // The receiver switches between steady, random, long-stall and periodic patterns.
  always @(posedge clk_i) begin
    if (cycle_count % 300 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: begin
        m_axis_tready <= 1'b1;
      end
      1: begin
        m_axis_tready <= ($urandom_range(0, 3) != 0);
      end
      2: begin
        m_axis_tready <= ($urandom_range(0, 15) == 0);
      end
      default: begin
        m_axis_tready <= ((cycle_count / 7) % 2 == 0);
      end
    endcase
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [RowW-1:0] value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    case (idx)
      CFG_ROW_X: coef_row[0] = value;
      CFG_ROW_Y: coef_row[1] = value;
      CFG_ROW_Z: coef_row[2] = value;
      CFG_OFF_X: shift_off[0] = value[PosW-1:0];
      CFG_OFF_Y: shift_off[1] = value[PosW-1:0];
      CFG_OFF_Z: shift_off[2] = value[PosW-1:0];
      default: ;
    endcase
  endtask

  task automatic send_vertex(input logic [127:0] d, input bit typed, input logic [127:0] want,
                             inout int burst_left);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = $urandom_range(1, 40);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= d;
    typed_flag <= typed;
    typed_want <= want;
    do @(posedge clk_i); while (!s_axis_tready);
    burst_left--;
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    typed_flag <= 1'b0;
    while (pending_vertices.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  initial begin
    vertex_row_t      directed [DirectedRows];
    logic [RowW-1:0]  rows [3];
    logic [PosW-1:0]  offs [3];
    int               burst_left;
    int               per_phase;
    burst_left = 0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_ROW_X;
    cfg_data_i = '0;
    typed_flag = 1'b0;
    typed_want = '0;
    coef_row[0] = IdentRowX;
    coef_row[1] = IdentRowY;
    coef_row[2] = IdentRowZ;
    shift_off[0] = '0;
    shift_off[1] = '0;
    shift_off[2] = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Identity matrix after reset: positions pass, axis-aligned normals stay at full scale.
    directed[0] = '{128'h0, 128'h0, 1'b1};
    directed[1] = '{{32'hFFFFFFFF, {3{32'h00800000}}},
                    {32'hFFFFFFFF, {3{32'h00800000}}}, 1'b1};
    directed[2] = '{{32'h0, {3{32'h00FFFFFF}}}, {32'h0, {3{32'h00FFFFFF}}}, 1'b1};
    directed[3] = '{{32'h0, 32'h00800000, 32'h00800000, 32'h7F800000},
                    {32'h0, 32'h00800000, 32'h00800000, 32'h7F800000}, 1'b1};
    directed[4] = '{{32'h0, 32'h00800000, 32'h00800000, 32'hFF800000},
                    {32'h0, 32'h00800000, 32'h00800000, 32'hFF800000}, 1'b1};
    directed[5] = '{{32'h5, {3{32'h80800000}}}, {32'h5, {3{32'h00800000}}}, 1'b1};
    directed[6] = '{{32'h0, 32'hFF000000, 32'h7F000000, 32'h81FFFFFF}, 128'h0, 1'b0};
    directed[7] = '{{32'hA5A5A5A5, {3{32'hFFFFFFFF}}}, 128'h0, 1'b0};
    directed[8] = '{{32'h0, {3{32'h7F000000}}}, 128'h0, 1'b0};
    directed[9] = '{{32'h0, 32'h01123456, 32'h81654321, 32'h40ABCDEF}, 128'h0, 1'b0};
    directed[10] = '{{32'h0, 32'h00000000, 32'h01000000, 32'h7F000000}, 128'h0, 1'b0};
    foreach (directed[k]) begin
      send_vertex(directed[k].din, directed[k].typed, directed[k].want, burst_left);
    end
    wait_idle();

    per_phase = RandomItems / 10;
    for (int phase = 0; phase < 10; phase++) begin
      case (phase)
        0: begin
          rows = '{48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF};
          offs = '{24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF};
        end
        1: begin
          rows = '{48'h8000_8000_8000, 48'h8000_8000_8000, 48'h8000_8000_8000};
          offs = '{24'h800000, 24'h800000, 24'h800000};
        end
        2: begin
          rows = '{48'h0, 48'h0, 48'h0};
          offs = '{24'h000001, 24'hFFFFFF, 24'h0};
        end
        3: begin
          rows = '{48'h0000_0000_1000, 48'h0000_1000_0000, 48'h0000_0000_0000};
          offs = '{24'h0, 24'h0, 24'h123456};
        end
        default: begin
          for (int r = 0; r < 3; r++) begin
            if ($urandom_range(0, 1)) begin
              rows[r] = 48'({$urandom, $urandom});
            end else begin
              rows[r] = {16'($urandom_range(0, 8191) - 4096), 16'($urandom_range(0, 8191) - 4096),
                         16'($urandom_range(0, 8191) - 4096)};
            end
            offs[r] = 24'($urandom);
          end
        end
      endcase
      write_reg(CFG_ROW_X, rows[0]);
      write_reg(CFG_ROW_Y, rows[1]);
      write_reg(CFG_ROW_Z, rows[2]);
      write_reg(CFG_OFF_X, {{(RowW-PosW){offs[0][PosW-1]}}, offs[0]});
      write_reg(CFG_OFF_Y, {24'($urandom), offs[1]});
      write_reg(CFG_OFF_Z, {24'h0, offs[2]});
      write_reg(IdxSpareLo, 48'({$urandom, $urandom}));
      write_reg(IdxSpareHi, 48'({$urandom, $urandom}));
      cfg_we_i <= 1'b0;
      @(posedge clk_i);
      for (int k = 0; k < per_phase; k++) begin
        send_vertex(random_vertex(), 1'b0, 128'h0, burst_left);
      end
      wait_idle();
    end

    if (mismatches == 0 && pending_vertices.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
